// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RFLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("rfls assertion failed");

// Next-cycle implication, held off during reset.
`define RFLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("rfls assertion failed");

`endif

// File: hdl/rfls_pkg.sv
// Types and constants of the ranging frame and line splitter.
package rfls_pkg;

	localparam int LINE_BUFFER_BYTES = 64;
	localparam int IDX_W             = $clog2(LINE_BUFFER_BYTES);

	localparam int FRAME_BYTES = 8;
	localparam int FRM_CNT_W   = $clog2(FRAME_BYTES);

	// command queue depth, power of two
	localparam int CMD_FIFO_DEPTH = 2;
	localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

	localparam logic [7:0] FRAME_HEAD     = 8'hF0;
	localparam logic [7:0] FRAME_LEN_BYTE = 8'h05;
	localparam logic [7:0] FRAME_TAIL     = 8'hAA;
	localparam logic [7:0] CHAR_LF        = 8'h0A;
	localparam logic [7:0] CHAR_CR        = 8'h0D;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		REC_FRAME = 2'd0,
		REC_BAD   = 2'd1,
		REC_CHAR  = 2'd2,
		REC_EMPTY = 2'd3
	} rec_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} bk_state_t;

	// job handed from front to back
	typedef struct packed {
		rec_kind_t          kind;
		logic [15:0]        addr;
		logic [15:0]        rng;
		logic signed [7:0]  rssi;
		idx_t               len;
	} cmd_t;

	// write port of the line store
	typedef struct packed {
		logic       en;
		idx_t       addr;
		logic [7:0] data;
	} mem_wr_t;

	// one result item
	typedef struct packed {
		rec_kind_t          kind;
		logic [15:0]        addr;
		logic [15:0]        rng;
		logic signed [7:0]  rssi;
		logic [7:0]         ch;
		logic               last;
	} rec_t;

endpackage

// File: hdl/rfls_front.sv
// Front end: takes bytes, tracks frame and line state, writes the store, queues jobs.
module rfls_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        rx_byte,
	input  logic              rx_valid,
	output logic              rx_ready,
	output logic              push,
	output rfls_pkg::cmd_t    cmd,
	input  logic              fifo_full,
	input  logic              line_done,
	output rfls_pkg::mem_wr_t mem_wr
);
	import rfls_pkg::*;

	logic                 accept;
	logic                 frame_start;
	logic                 frame_end;
	logic                 in_frame_q;
	logic [FRM_CNT_W-1:0] frm_cnt_q;
	logic [7:0]           frm_q [1:FRAME_BYTES-2];
	idx_t                 fill_q;
	logic                 zero_seen_q;
	idx_t                 zero_pos_q;
	logic                 last_cr_q;
	logic                 line_busy_q;
	logic                 room;
	idx_t                 line_len;
	idx_t                 line_n;

	assign rx_ready    = !line_busy_q && !fifo_full;
	assign accept      = rx_valid && rx_ready;
	assign frame_start = (rx_byte == FRAME_HEAD) && !in_frame_q && (fill_q == '0);
	assign frame_end   = in_frame_q && (frm_cnt_q == FRM_CNT_W'(FRAME_BYTES - 1));
	assign room        = fill_q < idx_t'(LINE_BUFFER_BYTES - 1);

	// trailing CR trimmed; the first zero byte, if any, ends the line instead
	assign line_len = fill_q - idx_t'((fill_q != '0) && last_cr_q);
	assign line_n   = zero_seen_q ? zero_pos_q : line_len;

	always_comb begin
		push = 1'b0;
		cmd  = '0;
		if (accept && !frame_start) begin
			if (frame_end) begin
				push = 1'b1;
				if ((frm_q[1] == FRAME_LEN_BYTE) && (rx_byte == FRAME_TAIL)) begin
					cmd.kind = REC_FRAME;
					cmd.addr = {frm_q[3], frm_q[2]};
					cmd.rng  = {frm_q[5], frm_q[4]};
					cmd.rssi = signed'(frm_q[6]);
				end else begin
					cmd.kind = REC_BAD;
				end
			end else if (!in_frame_q && (rx_byte == CHAR_LF)) begin
				push     = 1'b1;
				cmd.kind = (line_n == '0) ? REC_EMPTY : REC_CHAR;
				cmd.len  = line_n;
			end
		end
	end

	always_comb begin
		mem_wr.en   = accept && !frame_start && !in_frame_q && (rx_byte != CHAR_LF) && room;
		mem_wr.addr = fill_q;
		mem_wr.data = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			frm_cnt_q   <= '0;
			fill_q      <= '0;
			zero_seen_q <= 1'b0;
			zero_pos_q  <= '0;
			last_cr_q   <= 1'b0;
			line_busy_q <= 1'b0;
		end else begin
			if (line_done) begin
				line_busy_q <= 1'b0;
			end
			if (accept) begin
				if (frame_start) begin
					in_frame_q <= 1'b1;
					frm_cnt_q  <= FRM_CNT_W'(1);
				end else if (in_frame_q) begin
					if (frame_end) begin
						in_frame_q <= 1'b0;
					end else begin
						frm_cnt_q <= frm_cnt_q + FRM_CNT_W'(1);
					end
				end else if (rx_byte == CHAR_LF) begin
					fill_q      <= '0;
					zero_seen_q <= 1'b0;
					last_cr_q   <= 1'b0;
					// only a line with content is read back from the store
					line_busy_q <= (line_n != '0);
				end else if (room) begin
					fill_q    <= fill_q + idx_t'(1);
					last_cr_q <= (rx_byte == CHAR_CR);
					if ((rx_byte == 8'h00) && !zero_seen_q) begin
						zero_seen_q <= 1'b1;
						zero_pos_q  <= fill_q;
					end
				end else begin
					// overflow: line dropped silently
					fill_q      <= '0;
					zero_seen_q <= 1'b0;
					last_cr_q   <= 1'b0;
				end
			end
		end
	end

	// frame body bytes 1..6; byte 7 is checked as it arrives
	always_ff @(posedge clk) begin
		if (accept && in_frame_q && !frame_end) begin
			for (int i = 1; i <= FRAME_BYTES - 2; i++) begin
				if (frm_cnt_q == FRM_CNT_W'(i)) begin
					frm_q[i] <= rx_byte;
				end
			end
		end
	end

endmodule

// File: hdl/rfls_cmd_fifo.sv
// Short job queue between front and back.
module rfls_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rfls_pkg::cmd_t push_cmd,
	input  logic           pop,
	output rfls_pkg::cmd_t pop_cmd,
	output logic           full,
	output logic           empty
);
	import rfls_pkg::*;

	cmd_t                 slot_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = cnt_q == CMD_CNT_W'(CMD_FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CMD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hdl/rfls_back.sv
// Back end: holds the line store, runs jobs and drives the result register.
module rfls_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rfls_pkg::mem_wr_t mem_wr,
	input  logic              fifo_empty,
	input  rfls_pkg::cmd_t    cmd,
	output logic              pop,
	output logic              line_done,
	output rfls_pkg::rec_t    rec,
	output logic              rec_valid,
	input  logic              rec_ready
);
	import rfls_pkg::*;

	logic [7:0] mem [LINE_BUFFER_BYTES];
	logic [7:0] rd_data_q;
	logic       rd_en;
	idx_t       rd_addr;
	idx_t       idx_q;
	idx_t       len_q;
	bk_state_t  state_q;
	bk_state_t  state_d;
	logic       out_free;
	logic       is_last;
	logic       load;
	rec_t       load_rec;
	rec_t       rec_q;
	logic       rec_valid_q;

	assign out_free = !rec_valid_q || rec_ready;
	assign is_last  = idx_q == (len_q - idx_t'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_empty && out_free && (cmd.kind == REC_CHAR)) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (out_free && is_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		load      = 1'b0;
		load_rec  = '0;
		line_done = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_empty && out_free) begin
					pop = 1'b1;
					if (cmd.kind == REC_CHAR) begin
						rd_en = 1'b1;
					end else begin
						load          = 1'b1;
						load_rec.kind = cmd.kind;
						load_rec.addr = cmd.addr;
						load_rec.rng  = cmd.rng;
						load_rec.rssi = cmd.rssi;
						load_rec.last = 1'b1;
					end
				end
			end
			BK_READ: begin
				if (out_free) begin
					load          = 1'b1;
					load_rec.kind = REC_CHAR;
					load_rec.ch   = rd_data_q;
					load_rec.last = is_last;
					if (is_last) begin
						line_done = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + idx_t'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rec_valid_q <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
		end else begin
			state_q <= state_d;
			if (rd_en) begin
				idx_q <= rd_addr;
			end
			if (pop) begin
				len_q <= cmd.len;
			end
			if (load) begin
				rec_valid_q <= 1'b1;
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= load_rec;
		end
	end

	assign rec       = rec_q;
	assign rec_valid = rec_valid_q;

endmodule

// File: hdl/ranging_frame_and_line_splitter_core.sv
// Ranging frame and line splitter: top level.
//
// Takes one received serial byte per item and splits the stream into 8-byte
// ranging frames (0xF0 head while no line is pending, length byte 0x05, trailer
// 0xAA) and text lines closed by a newline. A frame gives one record: kind 0
// with sender address, distance and signed RSSI, or kind 1 when the length or
// trailer byte is wrong. A line is read back one character per item (kind 2,
// last on the final one), stops at the first zero byte, drops a trailing
// carriage return, and gives a single kind 3 record when it has no content.
// A line of more than 63 bytes is dropped at its 64th byte without any record.
// Fields without meaning for a record kind read zero.
// Timing: ordinary bytes and frame bytes are taken one per cycle while the
// two-entry job queue has room and no line is being read out. A frame record
// or an empty-line record goes through the job queue into the result register
// once that register is free. A newline that closes a line with content holds
// rx_ready low until the line has been read out of the store, one character
// at a time through the store's single registered read port and after any
// frame job still ahead in the queue; stalls on rec_ready lengthen this.
// No clearing pass follows reset.
module ranging_frame_and_line_splitter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  logic               rx_valid,
	output logic               rx_ready,
	output logic [1:0]         record_kind,
	output logic [15:0]        src_addr,
	output logic [15:0]        range_cm,
	output logic signed [7:0]  rssi_val,
	output logic [7:0]         line_char,
	output logic               last,
	output logic               rec_valid,
	input  logic               rec_ready
);
	import rfls_pkg::*;

	logic    push;
	cmd_t    push_cmd;
	cmd_t    pop_cmd;
	logic    pop;
	logic    fifo_full;
	logic    fifo_empty;
	logic    line_done;
	mem_wr_t mem_wr;
	rec_t    rec;

	// front: byte classification and store writes
	rfls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.push      (push),
		.cmd       (push_cmd),
		.fifo_full (fifo_full),
		.line_done (line_done),
		.mem_wr    (mem_wr)
	);

	// jobs: frame records and finished lines
	rfls_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	// back: store readout and result register
	rfls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mem_wr     (mem_wr),
		.fifo_empty (fifo_empty),
		.cmd        (pop_cmd),
		.pop        (pop),
		.line_done  (line_done),
		.rec        (rec),
		.rec_valid  (rec_valid),
		.rec_ready  (rec_ready)
	);

	assign record_kind = rec.kind;
	assign src_addr    = rec.addr;
	assign range_cm    = rec.rng;
	assign rssi_val    = rec.rssi;
	assign line_char   = rec.ch;
	assign last        = rec.last;

endmodule

// File: hdl/rfls_checker.sv
// Port-level checks of the splitter, bound to the top level.
`include "assert_macros.svh"

module rfls_checker (
	input logic              clk,
	input logic              arst_n,
	input logic [1:0]        record_kind,
	input logic [15:0]       src_addr,
	input logic [15:0]       range_cm,
	input logic signed [7:0] rssi_val,
	input logic [7:0]        line_char,
	input logic              last,
	input logic              rec_valid,
	input logic              rec_ready
);
	import rfls_pkg::*;

	`RFLS_ASSERT_NXT(a_rec_hold, clk, arst_n, rec_valid && !rec_ready, rec_valid && $stable(record_kind) && $stable(line_char) && $stable(last))
	`RFLS_ASSERT_IMP(a_single_last, clk, arst_n, rec_valid && (record_kind != REC_CHAR), last)
	`RFLS_ASSERT_IMP(a_char_nonzero, clk, arst_n, rec_valid && (record_kind == REC_CHAR), line_char != 8'h00)
	`RFLS_ASSERT_IMP(a_frame_fields, clk, arst_n, rec_valid && (record_kind != REC_FRAME), (src_addr == 16'h0) && (range_cm == 16'h0) && (rssi_val == 8'sh0))

endmodule

bind ranging_frame_and_line_splitter_core rfls_checker u_rfls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.record_kind (record_kind),
	.src_addr    (src_addr),
	.range_cm    (range_cm),
	.rssi_val    (rssi_val),
	.line_char   (line_char),
	.last        (last),
	.rec_valid   (rec_valid),
	.rec_ready   (rec_ready)
);
